// ===== rtl/flp_pkg.sv =====
package flp_pkg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned ELAPSED_W  = 32;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned PHASE_W    = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIGWAG_PERIOD = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_OFF     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_GAP     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIGWAG_REPS   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLASHES       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BURSTS        = 4'd7;

    // register reset values
    localparam logic [ELAPSED_W-1:0] RST_START_DELAY   = 32'd0;
    localparam logic [TIME_W-1:0]    RST_WIGWAG_PERIOD = 16'd400;
    localparam logic [TIME_W-1:0]    RST_FLASH_ON      = 16'd100;
    localparam logic [TIME_W-1:0]    RST_FLASH_OFF     = 16'd40;
    localparam logic [TIME_W-1:0]    RST_BURST_GAP     = 16'd300;
    localparam logic [COUNT_W-1:0]   RST_WIGWAG_REPS   = 4'd5;
    localparam logic [COUNT_W-1:0]   RST_FLASHES       = 4'd2;
    localparam logic [COUNT_W-1:0]   RST_BURSTS        = 4'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_WIG_A   = 3'd0,
        PH_WIG_B   = 3'd1,
        PH_WIG_END = 3'd2,
        PH_FL_ON   = 3'd3,
        PH_FL_OFF  = 3'd4,
        PH_GAP     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [ELAPSED_W-1:0] start_delay;
        logic [TIME_W-1:0]    wigwag_period;
        logic [TIME_W-1:0]    flash_on_time;
        logic [TIME_W-1:0]    flash_off_time;
        logic [TIME_W-1:0]    burst_gap;
        logic [COUNT_W-1:0]   wigwag_repeats;
        logic [COUNT_W-1:0]   flashes_per_burst;
        logic [COUNT_W-1:0]   bursts;
    } t_cfg;

    typedef struct packed {
        t_phase               phase;
        logic [ELAPSED_W-1:0] elapsed;
        logic [TIME_W-1:0]    wait_time;
        logic                 started;
        logic [COUNT_W-1:0]   inner_count;
        logic [COUNT_W-1:0]   outer_count;
        logic                 led_a;
        logic                 led_b;
    } t_state;

    localparam t_state STATE_RST = '{
        phase:       PH_WIG_A,
        elapsed:     '0,
        wait_time:   '0,
        started:     1'b0,
        inner_count: '0,
        outer_count: '0,
        led_a:       1'b0,
        led_b:       1'b0
    };

endpackage

// ===== rtl/flp_step.sv =====
module flp_step (
    input  flp_pkg::t_cfg   i_cfg,
    input  flp_pkg::t_state i_state,
    input  logic            i_tick,
    output flp_pkg::t_state o_state
);
    import flp_pkg::*;

    logic [ELAPSED_W-1:0] inc;
    logic [ELAPSED_W-1:0] target;
    logic                 fire;

    // elapsed saturates so that every wait is eventually reached
    assign inc    = (&i_state.elapsed) ? i_state.elapsed : i_state.elapsed + 1'b1;
    assign target = i_state.started ? {{(ELAPSED_W-TIME_W){1'b0}}, i_state.wait_time}
                                    : i_cfg.start_delay;
    assign fire   = i_tick && (inc >= target);

    always_comb begin
        o_state = i_state;
        if (i_tick) begin
            o_state.elapsed = inc;
        end
        if (fire) begin
            o_state.elapsed = '0;
            o_state.started = 1'b1;
            unique case (i_state.phase)
                PH_WIG_A: begin
                    o_state.led_a     = 1'b1;
                    o_state.wait_time = i_cfg.wigwag_period;
                    o_state.phase     = PH_WIG_B;
                end
                PH_WIG_B: begin
                    o_state.led_a     = 1'b0;
                    o_state.led_b     = 1'b1;
                    o_state.wait_time = i_cfg.wigwag_period;
                    o_state.phase     = PH_WIG_END;
                end
                PH_WIG_END: begin
                    o_state.led_b = 1'b0;
                    if (i_state.inner_count < i_cfg.wigwag_repeats) begin
                        o_state.wait_time   = '0;
                        o_state.phase       = PH_WIG_A;
                        o_state.inner_count = i_state.inner_count + 1'b1;
                    end else begin
                        o_state.wait_time   = i_cfg.wigwag_period;
                        o_state.phase       = PH_FL_ON;
                        o_state.inner_count = '0;
                    end
                end
                PH_FL_ON: begin
                    o_state.led_a     = 1'b1;
                    o_state.led_b     = 1'b1;
                    o_state.wait_time = i_cfg.flash_on_time;
                    o_state.phase     = PH_FL_OFF;
                end
                PH_FL_OFF: begin
                    o_state.led_a = 1'b0;
                    o_state.led_b = 1'b0;
                    if (i_state.inner_count < i_cfg.flashes_per_burst) begin
                        o_state.wait_time   = i_cfg.flash_off_time;
                        o_state.phase       = PH_FL_ON;
                        o_state.inner_count = i_state.inner_count + 1'b1;
                    end else begin
                        o_state.wait_time   = '0;
                        o_state.phase       = PH_GAP;
                        o_state.inner_count = '0;
                    end
                end
                PH_GAP: begin
                    o_state.wait_time = i_cfg.burst_gap;
                    if (i_state.outer_count < i_cfg.bursts) begin
                        o_state.phase       = PH_FL_ON;
                        o_state.outer_count = i_state.outer_count + 1'b1;
                    end else begin
                        o_state.phase       = PH_WIG_A;
                        o_state.outer_count = '0;
                    end
                end
                default: begin
                    // unused codes: elapsed restarts and started is set, nothing else changes
                end
            endcase
        end
    end

endmodule

// ===== rtl/two_led_flash_pattern_sequencer.sv =====
// Two-LED flash pattern sequencer: each input word carries one millisecond
// tick (or none) and yields one output word with both LED drives and the
// phase after that tick. One word is taken every clock cycle unless a
// result waits uncollected; its result is held in the output register
// in the next cycle, and a new word is taken in the same cycle that the
// waiting result is collected. Results pass through that single output
// register stage. Configuration writes are taken every cycle and should
// only be made while no result is outstanding.
module two_led_flash_pattern_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_tick,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_led_a,
    output logic                            o_led_b,
    output logic [flp_pkg::PHASE_W-1:0]     o_phase,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [flp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [flp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import flp_pkg::*;

    t_cfg   r_cfg;
    t_cfg   n_cfg;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_take;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_DELAY:   n_cfg.start_delay       = i_cfg_data;
                REG_WIGWAG_PERIOD: n_cfg.wigwag_period     = i_cfg_data[TIME_W-1:0];
                REG_FLASH_ON:      n_cfg.flash_on_time     = i_cfg_data[TIME_W-1:0];
                REG_FLASH_OFF:     n_cfg.flash_off_time    = i_cfg_data[TIME_W-1:0];
                REG_BURST_GAP:     n_cfg.burst_gap         = i_cfg_data[TIME_W-1:0];
                REG_WIGWAG_REPS:   n_cfg.wigwag_repeats    = i_cfg_data[COUNT_W-1:0];
                REG_FLASHES:       n_cfg.flashes_per_burst = i_cfg_data[COUNT_W-1:0];
                REG_BURSTS:        n_cfg.bursts            = i_cfg_data[COUNT_W-1:0];
                default: begin
                    // index beyond the register list: dropped
                end
            endcase
        end
    end

    t_state step_state;

    flp_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_tick  (i_tick),
        .o_state (step_state)
    );

    assign n_state     = in_take ? step_state : r_state;
    assign n_out_valid = in_take || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                start_delay:       RST_START_DELAY,
                wigwag_period:     RST_WIGWAG_PERIOD,
                flash_on_time:     RST_FLASH_ON,
                flash_off_time:    RST_FLASH_OFF,
                burst_gap:         RST_BURST_GAP,
                wigwag_repeats:    RST_WIGWAG_REPS,
                flashes_per_burst: RST_FLASHES,
                bursts:            RST_BURSTS
            };
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // the state after the last word doubles as the output word
    assign o_out_valid = r_out_valid;
    assign o_led_a     = r_state.led_a;
    assign o_led_b     = r_state.led_b;
    assign o_phase     = r_state.phase;

endmodule

// ===== rtl/flp_chk.sv =====
module flp_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        i_tick,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_led_a,
    input logic                        o_led_b,
    input logic [flp_pkg::PHASE_W-1:0] o_phase
);
    import flp_pkg::*;

    // a taken word always produces a result in the next cycle
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted word produced no result");

    // LED drives follow the phase
    a_led_by_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_phase == PH_WIG_B) && o_led_a && !o_led_b) ||
            ((o_phase == PH_WIG_END) && !o_led_a && o_led_b) ||
            ((o_phase == PH_FL_OFF) && o_led_a && o_led_b) ||
            (((o_phase == PH_WIG_A) || (o_phase == PH_FL_ON) || (o_phase == PH_GAP))
                && !o_led_a && !o_led_b))
        else $error("LED drives inconsistent with phase");

    // a word without a tick changes nothing
    a_idle_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_tick) |=>
            ($stable(o_phase) && $stable(o_led_a) && $stable(o_led_b)))
        else $error("idle word changed the pattern");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_phase)))
        else $error("stalled result dropped or changed");

endmodule

bind two_led_flash_pattern_sequencer flp_chk u_flp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_tick      (i_tick),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_led_a     (o_led_a),
    .o_led_b     (o_led_b),
    .o_phase     (o_phase)
);

// ===== verif/two_led_flash_pattern_sequencer_test.sv =====
module two_led_flash_pattern_sequencer_test;
    import flp_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic               led_a;
        logic               led_b;
        logic [PHASE_W-1:0] phase;
    } t_lamps;

    typedef struct packed {
        logic   tick;
        logic   typed;
        t_lamps lamps;
    } t_tick_row;

    typedef enum int {
        SET_SHORT_WAITS,
        SET_COUNTS_MAX,
        SET_COUNTS_ZERO,
        SET_WAITS_MAX,
        SET_ALL_ZERO
    } t_setting;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_tick      = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_led_a;
    logic                  o_led_b;
    logic [PHASE_W-1:0]    o_phase;
    logic                  o_cfg_ready;

    t_cfg   cfg_model;
    t_state seq_model;
    t_lamps pending_lamps[$];
    int     mismatch_count = 0;
    int     lamps_seen     = 0;
    int     idle_cycles    = 0;
    int     stall_left     = 0;
    bit     quiet          = 1'b0;
    bit     long_hold_done = 1'b0;

    // opening sequence: start delay 2, short waits, one repeat of each loop
    t_tick_row opening_rows [20] = '{
        '{1'b0, 1'b1, '{1'b0, 1'b0, PH_WIG_A}},  // straight after reset: dark
        '{1'b1, 1'b1, '{1'b0, 1'b0, PH_WIG_A}},  // start delay not yet reached
        '{1'b1, 1'b1, '{1'b1, 1'b0, PH_WIG_B}},  // first step lights A
        '{1'b0, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b0, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b0, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0},
        '{1'b1, 1'b0, '0}
    };

    t_setting plan [10] = '{
        SET_SHORT_WAITS, SET_COUNTS_MAX, SET_COUNTS_ZERO, SET_WAITS_MAX, SET_ALL_ZERO,
        SET_SHORT_WAITS, SET_COUNTS_MAX, SET_SHORT_WAITS, SET_COUNTS_ZERO, SET_SHORT_WAITS
    };

    two_led_flash_pattern_sequencer uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void advance_pattern();
        case (seq_model.phase)
            PH_WIG_A: begin
                seq_model.led_a     = 1'b1;
                seq_model.wait_time = cfg_model.wigwag_period;
                seq_model.phase     = PH_WIG_B;
            end
            PH_WIG_B: begin
                seq_model.led_a     = 1'b0;
                seq_model.led_b     = 1'b1;
                seq_model.wait_time = cfg_model.wigwag_period;
                seq_model.phase     = PH_WIG_END;
            end
            PH_WIG_END: begin
                seq_model.led_b = 1'b0;
                if (seq_model.inner_count < cfg_model.wigwag_repeats) begin
                    seq_model.wait_time   = '0;
                    seq_model.phase       = PH_WIG_A;
                    seq_model.inner_count = seq_model.inner_count + 1'b1;
                end else begin
                    seq_model.wait_time   = cfg_model.wigwag_period;
                    seq_model.phase       = PH_FL_ON;
                    seq_model.inner_count = '0;
                end
            end
            PH_FL_ON: begin
                seq_model.led_a     = 1'b1;
                seq_model.led_b     = 1'b1;
                seq_model.wait_time = cfg_model.flash_on_time;
                seq_model.phase     = PH_FL_OFF;
            end
            PH_FL_OFF: begin
                seq_model.led_a = 1'b0;
                seq_model.led_b = 1'b0;
                if (seq_model.inner_count < cfg_model.flashes_per_burst) begin
                    seq_model.wait_time   = cfg_model.flash_off_time;
                    seq_model.phase       = PH_FL_ON;
                    seq_model.inner_count = seq_model.inner_count + 1'b1;
                end else begin
                    seq_model.wait_time   = '0;
                    seq_model.phase       = PH_GAP;
                    seq_model.inner_count = '0;
                end
            end
            PH_GAP: begin
                seq_model.wait_time = cfg_model.burst_gap;
                if (seq_model.outer_count < cfg_model.bursts) begin
                    seq_model.phase       = PH_FL_ON;
                    seq_model.outer_count = seq_model.outer_count + 1'b1;
                end else begin
                    seq_model.phase       = PH_WIG_A;
                    seq_model.outer_count = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_lamps apply_tick(input logic t);
        logic [ELAPSED_W-1:0] target;
        t_lamps               r;
        if (t) begin
            // elapsed saturates, so even the longest wait is reached
            if (seq_model.elapsed != '1)
                seq_model.elapsed = seq_model.elapsed + 1'b1;
            target = {{(ELAPSED_W-TIME_W){1'b0}}, seq_model.wait_time};
            if (!seq_model.started)
                target = cfg_model.start_delay;
            if (seq_model.elapsed >= target) begin
                seq_model.elapsed = '0;
                seq_model.started = 1'b1;
                advance_pattern();
            end
        end
        r.led_a = seq_model.led_a;
        r.led_b = seq_model.led_b;
        r.phase = seq_model.phase;
        return r;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_START_DELAY:   cfg_model.start_delay       = val;
            REG_WIGWAG_PERIOD: cfg_model.wigwag_period     = val[TIME_W-1:0];
            REG_FLASH_ON:      cfg_model.flash_on_time     = val[TIME_W-1:0];
            REG_FLASH_OFF:     cfg_model.flash_off_time    = val[TIME_W-1:0];
            REG_BURST_GAP:     cfg_model.burst_gap         = val[TIME_W-1:0];
            REG_WIGWAG_REPS:   cfg_model.wigwag_repeats    = val[COUNT_W-1:0];
            REG_FLASHES:       cfg_model.flashes_per_burst = val[COUNT_W-1:0];
            REG_BURSTS:        cfg_model.bursts            = val[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] value_mask(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_START_DELAY:
                return '1;
            REG_WIGWAG_REPS, REG_FLASHES, REG_BURSTS:
                return {{(CFG_DATA_W-COUNT_W){1'b0}}, {COUNT_W{1'b1}}};
            default:
                return {{(CFG_DATA_W-TIME_W){1'b0}}, {TIME_W{1'b1}}};
        endcase
    endfunction

    function automatic void flag_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
        mismatch_count++;
        $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // leaves valid high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg_write(idx, val);
    endtask

    task automatic load_settings(input t_setting kind);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] field;
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        bit                    is_count;
        for (idx = REG_START_DELAY; idx <= REG_BURSTS; idx++) begin
            is_count = (idx >= REG_WIGWAG_REPS);
            case (kind)
                SET_SHORT_WAITS: field = is_count ? $urandom_range(0, 3) : $urandom_range(0, 5);
                SET_COUNTS_MAX:  field = is_count ? 32'd15 : 32'd0;
                SET_COUNTS_ZERO: field = is_count ? 32'd0 : $urandom_range(0, 2);
                SET_WAITS_MAX:   field = is_count ? $urandom_range(0, 15) : '1;
                default:         field = '0;
            endcase
            if (idx == REG_START_DELAY && kind == SET_SHORT_WAITS)
                field = $urandom;
            mask = value_mask(idx);
            junk = $urandom;
            write_reg(idx, (field & mask) | (junk & ~mask));
        end
        // an index past the last register must leave everything alone
        idx = CFG_IDX_W'($urandom_range(8, 15));
        write_reg(idx, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic feed_tick(input logic t, input logic typed, input t_lamps hand);
        t_lamps got;
        i_in_valid <= 1'b1;
        i_tick     <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        got = apply_tick(t);
        pending_lamps.push_back(typed ? hand : got);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_lamps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // output side: checking and back-pressure
    always @(posedge i_clk) begin
        t_lamps want;
        if (o_out_valid && i_out_ready) begin
            lamps_seen++;
            if (pending_lamps.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, actual %0b %0b %0d",
                         $time, o_led_a, o_led_b, o_phase);
            end else begin
                want = pending_lamps.pop_front();
                if (o_led_a !== want.led_a)
                    flag_field("led_a", 8'(want.led_a), 8'(o_led_a));
                if (o_led_b !== want.led_b)
                    flag_field("led_b", 8'(want.led_b), 8'(o_led_b));
                if (o_phase !== want.phase)
                    flag_field("phase", 8'(want.phase), 8'(o_phase));
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && lamps_seen >= 500) begin
            // long hold-off: the sender keeps offering until the block backs up
            long_hold_done = 1'b1;
            stall_left     = 80;
            i_out_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left   = $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int n_items;
        cfg_model = '{RST_START_DELAY, RST_WIGWAG_PERIOD, RST_FLASH_ON, RST_FLASH_OFF,
                      RST_BURST_GAP, RST_WIGWAG_REPS, RST_FLASHES, RST_BURSTS};
        seq_model = STATE_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // upper data bits are junk and must be dropped
        write_reg(REG_START_DELAY,   32'd2);
        write_reg(REG_WIGWAG_PERIOD, 32'hFFFF_0001);
        write_reg(REG_FLASH_ON,      32'hA5A5_0000);
        write_reg(REG_FLASH_OFF,     32'h0001_0001);
        write_reg(REG_BURST_GAP,     32'hFFFF_0000);
        write_reg(REG_WIGWAG_REPS,   32'hFFFF_FFF1);
        write_reg(REG_FLASHES,       32'h0000_00F1);
        write_reg(REG_BURSTS,        32'h8000_0011);
        write_reg(4'd8,              32'hFFFF_FFFF);
        write_reg(4'd15,             32'h0000_0000);
        i_cfg_valid <= 1'b0;

        foreach (opening_rows[i])
            feed_tick(opening_rows[i].tick, opening_rows[i].typed, opening_rows[i].lamps);

        foreach (plan[p]) begin
            drain_results();
            if (p == $size(plan) - 1)
                quiet = 1'b1;
            load_settings(plan[p]);
            n_items = (plan[p] == SET_WAITS_MAX) ? 100 : 185;
            for (int n = 0; n < n_items; n++) begin
                feed_tick($urandom_range(0, 4) != 0, 1'b0, '0);
                if (p == 6 && n == 80)
                    drain_results();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_lamps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/flp_pkg.sv
rtl/flp_step.sv
rtl/two_led_flash_pattern_sequencer.sv
rtl/flp_chk.sv
verif/two_led_flash_pattern_sequencer_test.sv
